// File: design/sha256_byte_stream_hasher_defines.svh
// Assertion macros for the SHA-256 byte stream hasher.
// Included by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Hold cons in the same cycle as ante.
`define SHBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Hold cons in the cycle after ante.
`define SHBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/shbs_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; used by the front, back and top level modules.
`timescale 1ns / 1ps

package shbs_pkg;

    localparam int QueueDepth = 2;

    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        blk_t blk;
        logic last_blk;
    } qent_t;

    typedef enum logic [1:0] {
        F_COLLECT,
        F_PAD1,
        F_PAD2
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROUND,
        B_FOLD
    } back_state_t;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitVec [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// File: design/shbs_fifo.sv
// Small first-in first-out queue of generic width and depth in flip-flops.
// No dependencies.
`timescale 1ns / 1ps

module shbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/shbs_front.sv
// Front end: packs message bytes into 512-bit blocks, adds padding and length.
// Depends on shbs_pkg; feeds whole blocks into the block queue.
`timescale 1ns / 1ps

module shbs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      data_byte,
    input  logic            has_byte,
    input  logic            last_item,
    output logic            q_push,
    output shbs_pkg::qent_t q_data,
    input  logic            q_full
);

    shbs_pkg::front_state_t state_reg;
    shbs_pkg::front_state_t state_next;
    shbs_pkg::blk_t         blk_reg;
    shbs_pkg::blk_t         merged;
    shbs_pkg::blk_t         pad_blk;
    logic [5:0]             fill_reg;
    logic [63:0]            bits_reg;
    logic [63:0]            total_reg;
    logic [5:0]             fill_after;
    logic [63:0]            bits_after;
    logic                   accept;
    logic                   blk_done;
    logic                   short_tail;

    assign full       = (state_reg != shbs_pkg::F_COLLECT) || q_full;
    assign accept     = push && !full;
    assign blk_done   = has_byte && (fill_reg == 6'd63);
    assign fill_after = !has_byte ? fill_reg : (blk_done ? 6'd0 : fill_reg + 6'd1);
    assign bits_after = blk_done ? bits_reg + 64'd512 : bits_reg;
    assign short_tail = (fill_reg < 6'd56);

    always_comb
    begin
        merged = blk_reg;
        merged[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = data_byte;
    end

    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            pad_blk[i >> 2][8 * (3 - (i & 3)) +: 8] = 8'h00;
            if (state_reg == shbs_pkg::F_PAD1)
            begin
                if (6'(i) < fill_reg)
                begin
                    pad_blk[i >> 2][8 * (3 - (i & 3)) +: 8] =
                        blk_reg[i >> 2][8 * (3 - (i & 3)) +: 8];
                end
                else if (6'(i) == fill_reg)
                begin
                    pad_blk[i >> 2][8 * (3 - (i & 3)) +: 8] = shbs_pkg::PadByte;
                end
            end
        end
        for (int i = 56; i < 64; i++)
        begin
            if (state_reg == shbs_pkg::F_PAD2 || short_tail)
            begin
                pad_blk[i >> 2][8 * (3 - (i & 3)) +: 8] = total_reg[8 * (63 - i) +: 8];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shbs_pkg::F_COLLECT:
            begin
                if (accept && last_item)
                begin
                    state_next = shbs_pkg::F_PAD1;
                end
            end
            shbs_pkg::F_PAD1:
            begin
                if (!q_full)
                begin
                    state_next = short_tail ? shbs_pkg::F_COLLECT : shbs_pkg::F_PAD2;
                end
            end
            shbs_pkg::F_PAD2:
            begin
                if (!q_full)
                begin
                    state_next = shbs_pkg::F_COLLECT;
                end
            end
            default:
            begin
                state_next = shbs_pkg::F_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        q_push          = 1'b0;
        q_data.blk      = pad_blk;
        q_data.last_blk = 1'b0;
        case (state_reg)
            shbs_pkg::F_COLLECT:
            begin
                q_push     = accept && blk_done;
                q_data.blk = merged;
            end
            shbs_pkg::F_PAD1:
            begin
                q_push          = !q_full;
                q_data.last_blk = short_tail;
            end
            shbs_pkg::F_PAD2:
            begin
                q_push          = !q_full;
                q_data.last_blk = 1'b1;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (has_byte)
            begin
                blk_reg <= merged;
            end
            total_reg <= bits_after + {55'd0, fill_after, 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shbs_pkg::F_COLLECT;
            fill_reg  <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                fill_reg <= fill_after;
                bits_reg <= bits_after;
            end
            else if (state_reg != shbs_pkg::F_COLLECT
                     && state_next == shbs_pkg::F_COLLECT)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
            end
        end
    end

endmodule

// File: design/shbs_back.sv
// Back end: 64-round SHA-256 compression, chaining words and digest output.
// Depends on shbs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_defines.svh"

module shbs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  shbs_pkg::qent_t q_data,
    output logic            q_pop,
    output logic [63:0]     digest_word,
    output logic [1:0]      word_index,
    output logic            last_word,
    output logic            empty,
    input  logic            pop
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    shbs_pkg::back_state_t state_reg;
    shbs_pkg::back_state_t state_next;
    logic [31:0]           h_reg [8];
    logic [31:0]           v_reg [8];
    logic [31:0]           w_reg [16];
    logic [5:0]            round_reg;
    logic                  last_reg;
    logic [3:0][63:0]      dig_reg;
    logic [1:0]            ptr_reg;
    logic                  pend_reg;
    logic [31:0]           s0;
    logic [31:0]           s1;
    logic [31:0]           w_new;
    logic [31:0]           t1;
    logic [31:0]           t2;
    logic                  fold_go;
    logic                  out_pop;

    assign s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign t1    = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
                 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                 + shbs_pkg::RoundK[round_reg] + w_reg[0];
    assign t2    = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
                 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign fold_go     = (state_reg == shbs_pkg::B_FOLD) && !(last_reg && pend_reg);
    assign out_pop     = pop && pend_reg;
    assign empty       = !pend_reg;
    assign digest_word = dig_reg[ptr_reg];
    assign word_index  = ptr_reg;
    assign last_word   = (ptr_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shbs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = shbs_pkg::B_ROUND;
                end
            end
            shbs_pkg::B_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = shbs_pkg::B_FOLD;
                end
            end
            shbs_pkg::B_FOLD:
            begin
                if (fold_go)
                begin
                    state_next = shbs_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = shbs_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        case (state_reg)
            shbs_pkg::B_IDLE:
            begin
                q_pop = !q_empty;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == shbs_pkg::B_IDLE && !q_empty)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= q_data.blk[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
            last_reg <= q_data.last_blk;
        end
        else if (state_reg == shbs_pkg::B_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= v_reg[5];
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= v_reg[3] + t1;
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= v_reg[1];
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1 + t2;
        end
        if (fold_go && last_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                dig_reg[k] <= {h_reg[2 * k] + v_reg[2 * k], h_reg[2 * k + 1] + v_reg[2 * k + 1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shbs_pkg::B_IDLE;
            round_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= shbs_pkg::InitVec[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == shbs_pkg::B_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            else
            begin
                round_reg <= '0;
            end
            if (fold_go)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= last_reg ? shbs_pkg::InitVec[i] : h_reg[i] + v_reg[i];
                end
            end
            if (fold_go && last_reg)
            begin
                pend_reg <= 1'b1;
                ptr_reg  <= '0;
            end
            else if (out_pop)
            begin
                ptr_reg <= ptr_reg + 2'd1;
                if (ptr_reg == 2'd3)
                begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

    `SHBS_ASSERT_NEXT(a_load_starts, state_reg == shbs_pkg::B_IDLE && !q_empty, state_reg == shbs_pkg::B_ROUND && round_reg == 6'd0, "block load did not start rounds")
    `SHBS_ASSERT_NEXT(a_rounds_end, state_reg == shbs_pkg::B_ROUND && round_reg == 6'd63, state_reg == shbs_pkg::B_FOLD, "round 63 not followed by fold")
    `SHBS_ASSERT_NEXT(a_drain, out_pop && ptr_reg == 2'd3 && !fold_go, !pend_reg, "digest still pending after last slice")
    `SHBS_ASSERT_NOW(a_no_overwrite, fold_go && last_reg, !pend_reg, "digest overwritten before drained")

endmodule

// File: design/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: front end, block queue, back end.
// Depends on shbs_pkg, shbs_front, shbs_fifo and shbs_back.
//
//   channel  | handshake    | payload
//   ---------+--------------+-------------------------------------
//   input    | push / full  | data_byte, has_byte, last_item
//   result   | pop / empty  | digest_word, word_index, last_word
//
// A byte is taken on each push while not full; a full block then runs in the round engine
// (load, 64 rounds, fold), one round per cycle, while the front keeps collecting.
// The front stalls (full) only when the block queue is full or while it writes pad blocks.
// The last item yields four results after one or two more blocks, the second when the
// tail leaves 8 bytes or fewer free. Reset is asynchronous and restores the initial vector.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = shbs_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_item,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    localparam int QW = $bits(shbs_pkg::qent_t);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    shbs_pkg::qent_t q_in;
    shbs_pkg::qent_t q_out;
    logic [QW-1:0]   q_out_bits;

    assign q_out = shbs_pkg::qent_t'(q_out_bits);

    shbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last_item (last_item),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    shbs_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out_bits),
        .empty     (q_empty)
    );

    shbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
